### rtl/k_stk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_stk_pkg
// Shared constants for the shared-buffer stack block: field widths,
// operation and status codes, parameter defaults.
// ----------------------------------------------------------------------------
package k_stk_pkg;

    // payload field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // parameter defaults
    localparam int DEPTH_DEF      = 16;
    localparam int STACKS_DEF     = 4;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

### rtl/k_stacks_shared_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_stacks_shared_buffer
// Several stacks sharing one element store, with a linked free list.
// ----------------------------------------------------------------------------
// Each input transaction is a push, pop or peek on one stack; each gives
// exactly one result transaction (status and data). At accept the block
// issues the synchronous reads of the element RAM and the link RAM; the
// execute step then uses the read data, writes the RAMs back and loads the
// result register. Because of the read-then-write on the link RAM, the block
// takes no new transaction before the last one has executed; execute waits
// while a finished result is not taken. Link entries never written count as
// links to the next slot through a frontier mark (the count of slots ever
// handed out), so there is no clearing pass after reset.
// Element entries are undefined until pushed and can never be popped before.
// ----------------------------------------------------------------------------
module k_stacks_shared_buffer
    import k_stk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int STACKS     = STACKS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ID_W-1:0]     i_stack_id,
    input  logic [VAL_W-1:0]    i_value,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VAL_W-1:0]    o_data
);

    localparam int AW     = $clog2(DEPTH);
    localparam int PTR_W  = AW + 1;                      // slot index or none
    localparam int TIDX_W = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [PTR_W-1:0] PTR_NONE  = '1;
    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);

    // control and state
    logic                  r_busy;
    logic [PTR_W-1:0]      r_free_head, n_free_head;
    logic [PTR_W-1:0]      r_frontier,  n_frontier;
    logic [PTR_W-1:0]      r_stack_top [STACKS];

    // captured transaction
    logic [OP_W-1:0]       r_op;
    logic [ID_W-1:0]       r_sid;
    logic                  r_sid_ok;
    logic [VAL_W-1:0]      r_value;
    logic [PTR_W-1:0]      r_top;

    // result register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [VAL_W-1:0]      r_data,   n_data;

    // handshakes
    logic                  w_in_fire;
    logic                  w_exec;

    // accept-side lookups
    logic                  w_in_sid_ok;
    logic [TIDX_W-1:0]     w_in_tidx;
    logic [PTR_W-1:0]      w_in_top;
    logic [AW-1:0]         w_link_raddr;

    // execute-side writes
    logic                  w_top_we;
    logic [PTR_W-1:0]      w_top_wdata;
    logic                  w_link_we;
    logic [AW-1:0]         w_link_waddr;
    logic [PTR_W-1:0]      w_link_wdata;
    logic                  w_elem_we;

    // ram read data
    logic [PTR_W-1:0]      w_link_rdata;
    logic [DATA_WIDTH-1:0] w_elem_rdata;

    assign o_ready   = !r_busy;
    assign w_in_fire = i_valid && o_ready;
    // result register is free or being emptied this cycle
    assign w_exec    = r_busy && (!r_out_valid || i_ready);

    // stack top lookup at accept; an id beyond the stack count acts empty and overflows on push
    assign w_in_sid_ok = int'(i_stack_id) < STACKS;
    assign w_in_tidx   = TIDX_W'(i_stack_id);
    assign w_in_top    = w_in_sid_ok ? r_stack_top[w_in_tidx] : PTR_NONE;

    // push reads the link of the free head, pop reads the link of the top
    assign w_link_raddr = (i_operation == OP_PUSH) ? r_free_head[AW-1:0]
                                                   : w_in_top[AW-1:0];

    k_stk_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_elem_we),
        .i_waddr (r_free_head[AW-1:0]),
        .i_wdata (DATA_WIDTH'(r_value)),
        .i_re    (w_in_fire),
        .i_raddr (w_in_top[AW-1:0]),
        .o_rdata (w_elem_rdata)
    );

    k_stk_ram #(
        .WIDTH (PTR_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_re    (w_in_fire),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rdata)
    );

    // execute: status, data and all state updates of one transaction
    always_comb begin
        n_status     = ST_OK;
        n_data       = '0;
        n_free_head  = r_free_head;
        n_frontier   = r_frontier;
        w_top_we     = 1'b0;
        w_top_wdata  = r_free_head;
        w_link_we    = 1'b0;
        w_link_waddr = r_free_head[AW-1:0];
        w_link_wdata = r_top;
        w_elem_we    = 1'b0;
        case (r_op) inside
            OP_PUSH: begin
                if (!r_sid_ok || r_free_head >= PTR_DEPTH) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    // new slot links to the old top and becomes the top
                    w_elem_we   = w_exec;
                    w_link_we   = w_exec;
                    w_top_we    = w_exec;
                    if (r_free_head >= r_frontier) begin
                        // slot from the never-used region: its link is the next slot
                        n_free_head = r_free_head + PTR_W'(1);
                        n_frontier  = r_free_head + PTR_W'(1);
                    end else begin
                        n_free_head = w_link_rdata;
                    end
                end
            end
            OP_POP, OP_PEEK: begin
                if (r_top >= PTR_DEPTH) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_data = VAL_W'(w_elem_rdata);
                    if (r_op == OP_POP) begin
                        // top slot goes back to the head of the free list
                        w_top_we     = w_exec;
                        w_top_wdata  = w_link_rdata;
                        w_link_we    = w_exec;
                        w_link_waddr = r_top[AW-1:0];
                        w_link_wdata = r_free_head;
                        n_free_head  = r_top;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_free_head <= '0;
            r_frontier  <= '0;
            for (int i = 0; i < STACKS; i++) begin
                r_stack_top[i] <= PTR_NONE;
            end
        end else begin
            if (w_in_fire) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end

            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_free_head <= n_free_head;
                r_frontier  <= n_frontier;
                if (w_top_we) begin
                    r_stack_top[TIDX_W'(r_sid)] <= w_top_wdata;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op     <= i_operation;
            r_sid    <= i_stack_id;
            r_sid_ok <= w_in_sid_ok;
            r_value  <= i_value;
            r_top    <= w_in_top;
        end
        if (w_exec) begin
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_data   = r_data;

endmodule

### rtl/k_stk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_stk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module k_stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/k_stk_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_stk_chk
// Port-level checks for the shared-buffer stack block, bound to the top.
// ----------------------------------------------------------------------------
module k_stk_chk
    import k_stk_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [OP_W-1:0]     i_operation,
    input logic [ID_W-1:0]     i_stack_id,
    input logic [VAL_W-1:0]    i_value,
    input logic                o_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [VAL_W-1:0]    o_data
);

    // no result pending and ready right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending or not ready after reset");

    // error results carry zero data
    a_err_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_data == '0)
        else $error("nonzero data with error status");

    // one transaction in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_data))
        else $error("stalled result changed");

endmodule

bind k_stacks_shared_buffer k_stk_chk u_k_stk_chk (.*);
